// ===== hw/rtl/hkra_pkg.sv =====
// Package for the HID keyboard report to ASCII converter: request types,
// key codes, state encoding and the US keymap lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hkra_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int SLOT_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int MAP_SIZE  = 90;

    localparam logic REQ_REPORT = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    localparam logic [7:0] MOD_SHIFT   = 8'h22;
    localparam logic [7:0] MOD_CTRL    = 8'h11;
    localparam logic [7:0] CODE_RIGHT  = 8'h4f;
    localparam logic [7:0] CODE_LEFT   = 8'h50;
    localparam logic [7:0] CODE_DOWN   = 8'h51;
    localparam logic [7:0] CODE_UP     = 8'h52;
    localparam logic [7:0] CODE_DELETE = 8'h4c;
    localparam logic [7:0] CODE_M      = 8'h10;

    localparam logic [6:0] CHAR_ESC    = 7'h1b;
    localparam logic [6:0] CHAR_LBRACK = 7'h5b;
    localparam logic [6:0] CHAR_DEL    = 7'h7f;
    localparam logic [6:0] CHAR_CTRL_M = 7'd28;
    localparam logic [6:0] CTRL_MASK   = 7'h1f;

    // Arrow sequences are ESC, '[', letter
    localparam logic [1:0] STEP_ESC    = 2'd0;
    localparam logic [1:0] STEP_LBRACK = 2'd1;
    localparam logic [1:0] STEP_LETTER = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] modifier_bits;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } report_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_of_run;
    } char_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    // One generated character for a key and whether the key is finished
    typedef struct packed {
        logic       valid;
        logic [6:0] ch;
        logic       end_key;
    } gen_t;

    function automatic logic [6:0] us_char(input logic [6:0] code, input logic shift);
        logic [6:0] ch;
        begin
            ch = '0;
            case (code)
                7'd30:   ch = shift ? 7'h21 : 7'h31;
                7'd31:   ch = shift ? 7'h40 : 7'h32;
                7'd32:   ch = shift ? 7'h23 : 7'h33;
                7'd33:   ch = shift ? 7'h24 : 7'h34;
                7'd34:   ch = shift ? 7'h25 : 7'h35;
                7'd35:   ch = shift ? 7'h5e : 7'h36;
                7'd36:   ch = shift ? 7'h26 : 7'h37;
                7'd37:   ch = shift ? 7'h2a : 7'h38;
                7'd38:   ch = shift ? 7'h28 : 7'h39;
                7'd39:   ch = shift ? 7'h29 : 7'h30;
                7'd40:   ch = 7'h0d;
                7'd41:   ch = 7'h1b;
                7'd42:   ch = 7'h08;
                7'd43:   ch = 7'h09;
                7'd44:   ch = 7'h20;
                7'd45:   ch = shift ? 7'h5f : 7'h2d;
                7'd46:   ch = shift ? 7'h2b : 7'h3d;
                7'd47:   ch = shift ? 7'h7b : 7'h5b;
                7'd48:   ch = shift ? 7'h7d : 7'h5d;
                7'd49:   ch = shift ? 7'h7c : 7'h5c;
                7'd51:   ch = shift ? 7'h3a : 7'h3b;
                7'd52:   ch = shift ? 7'h22 : 7'h27;
                7'd53:   ch = shift ? 7'h7e : 7'h60;
                7'd54:   ch = shift ? 7'h3c : 7'h2c;
                7'd55:   ch = shift ? 7'h3e : 7'h2e;
                7'd56:   ch = shift ? 7'h3f : 7'h2f;
                default:
                begin
                    if (code >= 7'd4 && code <= 7'd29)
                        ch = (shift ? 7'h41 : 7'h61) + (code - 7'd4);
                    else
                        ch = '0;
                end
            endcase
            return ch;
        end
    endfunction

    function automatic gen_t gen_char(input logic [7:0] mods, input logic [7:0] code,
                                      input logic [1:0] step);
        gen_t       g;
        logic [6:0] ch;
        logic       shift;
        logic       ctrl;
        logic       letter;
        begin
            g      = '0;
            shift  = |(mods & MOD_SHIFT);
            ctrl   = |(mods & MOD_CTRL);
            ch     = us_char(code[6:0], shift);
            letter = (ch >= 7'h61 && ch <= 7'h7a) || (ch >= 7'h41 && ch <= 7'h5a);
            if (code == CODE_RIGHT || code == CODE_LEFT || code == CODE_DOWN
                || code == CODE_UP)
            begin
                g.valid   = 1'b1;
                g.end_key = (step == STEP_LETTER);
                case (step)
                    STEP_ESC:    g.ch = CHAR_ESC;
                    STEP_LBRACK: g.ch = CHAR_LBRACK;
                    default:
                    begin
                        if (code == CODE_RIGHT)
                            g.ch = 7'h43;
                        else if (code == CODE_LEFT)
                            g.ch = 7'h44;
                        else if (code == CODE_DOWN)
                            g.ch = 7'h42;
                        else
                            g.ch = 7'h41;
                    end
                endcase
            end
            else if (code == CODE_DELETE)
            begin
                g.valid   = 1'b1;
                g.end_key = 1'b1;
                g.ch      = CHAR_DEL;
            end
            else if (code >= 8'(MAP_SIZE) || ch == '0)
            begin
                g.valid   = 1'b0;
                g.end_key = 1'b1;
            end
            else
            begin
                g.valid   = 1'b1;
                g.end_key = 1'b1;
                if (ctrl && letter)
                    g.ch = (code == CODE_M) ? CHAR_CTRL_M : (ch & CTRL_MASK);
                else
                    g.ch = ch;
            end
            return g;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hid_keyboard_report_to_ascii.sv =====
// HID boot keyboard report to ASCII converter, top level.
// Depends on hkra_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one boot keyboard report per request (modifier byte plus six key
// slots) and emits one 7-bit character per output request for every key
// that was not down in the previous report, in slot order. Arrow keys give
// ESC '[' A/B/C/D, Delete gives 0x7F, other codes go through the US map
// with shift picking the shifted column and ctrl folding letters to control
// codes (ctrl+M gives 28). The last character of a report carries
// last_of_run. A clear request (req_type = 1) zeroes the key history when it is
// accepted and gives no characters.
// Sequence: once a report is accepted, a single 8-bit comparator walks the
// history for each slot in turn, then each new key emits its characters
// (a new key with no character still passes through the emit state), and
// last the final character is handed over in the flush state. Stall from
// the output side can hold the emit and flush states. report_stall is
// high from the accepting edge until the block is back in idle.
module hid_keyboard_report_to_ascii
    import hkra_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    report_valid,
    output logic         report_stall,
    input  wire report_t report,
    output logic         char_valid,
    input  wire logic    char_stall,
    output char_t        char_data
);

    state_t state_reg;
    state_t state_next;

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [SLOT_W-1:0] cmp_reg;
    logic [SLOT_W-1:0] cmp_next;
    logic [1:0]        step_reg;
    logic [1:0]        step_next;
    logic              seen_reg;
    logic              seen_next;
    logic [7:0]        mods_reg;
    logic [7:0]        mods_next;

    logic [KEY_SLOTS-1:0][7:0] cur_keys_reg;
    logic [KEY_SLOTS-1:0][7:0] cur_keys_next;
    logic [KEY_SLOTS-1:0][7:0] prev_keys_reg;
    logic [KEY_SLOTS-1:0][7:0] prev_keys_next;

    // One character is held back so the final one can be flagged
    logic       hold_vld_reg;
    logic       hold_vld_next;
    logic [6:0] hold_char_reg;
    logic [6:0] hold_char_next;

    logic  out_vld_reg;
    logic  out_vld_next;
    char_t out_reg;
    char_t out_next;

    logic [5:0][7:0] all_slots;
    logic [7:0]      cur_code;
    logic [7:0]      prev_code;
    logic            hit;
    logic            skip_key;
    logic            slot_last;
    logic            cmp_last;
    logic            out_free;
    logic            report_acc;
    logic            emit_go;
    logic            flush_go;
    gen_t            gen;

    assign all_slots = {report.key_slot_5, report.key_slot_4, report.key_slot_3,
                        report.key_slot_2, report.key_slot_1, report.key_slot_0};

    // Shared comparator: current slot code against one history entry a cycle
    assign cur_code  = cur_keys_reg[slot_reg];
    assign prev_code = prev_keys_reg[cmp_reg];
    assign hit       = (cur_code == prev_code);
    assign skip_key  = seen_reg || hit || (cur_code == '0);
    assign slot_last = (slot_reg == SLOT_W'(KEY_SLOTS - 1));
    assign cmp_last  = (cmp_reg == SLOT_W'(KEY_SLOTS - 1));
    assign gen       = gen_char(mods_reg, cur_code, step_reg);

    assign report_stall = (state_reg != ST_IDLE);
    assign report_acc   = report_valid && !report_stall;
    assign out_free     = !out_vld_reg || !char_stall;
    assign emit_go      = gen.valid && (!hold_vld_reg || out_free);
    assign flush_go     = !hold_vld_reg || out_free;

    assign char_valid = out_vld_reg;
    assign char_data  = out_reg;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (report_acc && report.req_type == REQ_REPORT)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (cmp_last)
                begin
                    if (!skip_key)
                        state_next = ST_EMIT;
                    else if (slot_last)
                        state_next = ST_FLUSH;
                end
            end
            ST_EMIT:
            begin
                if (!gen.valid || (emit_go && gen.end_key))
                    state_next = slot_last ? ST_FLUSH : ST_CMP;
            end
            ST_FLUSH:
            begin
                if (flush_go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register
    always_comb
    begin
        slot_next      = slot_reg;
        cmp_next       = cmp_reg;
        step_next      = step_reg;
        seen_next      = seen_reg;
        mods_next      = mods_reg;
        cur_keys_next  = cur_keys_reg;
        prev_keys_next = prev_keys_reg;
        hold_vld_next  = hold_vld_reg;
        hold_char_next = hold_char_reg;
        out_vld_next   = out_vld_reg && char_stall;
        out_next       = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (report_acc)
                begin
                    if (report.req_type == REQ_CLEAR)
                    begin
                        prev_keys_next = '0;
                    end
                    else
                    begin
                        cur_keys_next = all_slots[KEY_SLOTS-1:0];
                        mods_next     = report.modifier_bits;
                        slot_next     = '0;
                        cmp_next      = '0;
                        step_next     = '0;
                        seen_next     = 1'b0;
                    end
                end
            end
            ST_CMP:
            begin
                if (cmp_last)
                begin
                    cmp_next  = '0;
                    seen_next = 1'b0;
                    step_next = '0;
                    if (skip_key && !slot_last)
                        slot_next = slot_reg + 1'b1;
                end
                else
                begin
                    cmp_next  = cmp_reg + 1'b1;
                    seen_next = seen_reg || hit;
                end
            end
            ST_EMIT:
            begin
                if (!gen.valid)
                begin
                    if (!slot_last)
                        slot_next = slot_reg + 1'b1;
                end
                else if (emit_go)
                begin
                    hold_vld_next  = 1'b1;
                    hold_char_next = gen.ch;
                    if (hold_vld_reg)
                    begin
                        out_vld_next          = 1'b1;
                        out_next.char_code    = hold_char_reg;
                        out_next.last_of_run  = 1'b0;
                    end
                    if (gen.end_key)
                    begin
                        step_next = '0;
                        if (!slot_last)
                            slot_next = slot_reg + 1'b1;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (flush_go)
                begin
                    if (hold_vld_reg)
                    begin
                        out_vld_next         = 1'b1;
                        out_next.char_code   = hold_char_reg;
                        out_next.last_of_run = 1'b1;
                    end
                    hold_vld_next  = 1'b0;
                    prev_keys_next = cur_keys_reg;
                end
            end
            default:
            begin
                hold_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            cmp_reg       <= '0;
            step_reg      <= '0;
            seen_reg      <= 1'b0;
            prev_keys_reg <= '0;
            hold_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            cmp_reg       <= cmp_next;
            step_reg      <= step_next;
            seen_reg      <= seen_next;
            prev_keys_reg <= prev_keys_next;
            hold_vld_reg  <= hold_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mods_reg      <= mods_next;
        cur_keys_reg  <= cur_keys_next;
        hold_char_reg <= hold_char_next;
        out_reg       <= out_next;
    end

    // Nothing is held back between reports
    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_vld_reg)
        else $error("held character left over while idle");

    // Clear request wipes the whole history
    a_clear_wipes: assert property (@(posedge clk) disable iff (!rst_n)
        (report_acc && report.req_type == REQ_CLEAR) |=> (prev_keys_reg == '0))
        else $error("history not cleared");

    // Final hand-over flags the character and returns to idle
    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && hold_vld_reg && out_free)
        |=> (state_reg == ST_IDLE && out_vld_reg && out_reg.last_of_run))
        else $error("final character not flagged");

    // Counters stay inside the slot range and arrow sequence length
    a_counters_range: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_reg <= SLOT_W'(KEY_SLOTS - 1)) && (cmp_reg <= SLOT_W'(KEY_SLOTS - 1))
        && (step_reg <= STEP_LETTER))
        else $error("sequencer counter out of range");

    // A character leaving during a report is never flagged as last
    a_mid_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && emit_go && hold_vld_reg)
        |=> (out_vld_reg && !out_reg.last_of_run))
        else $error("mid-report character flagged as last");

endmodule

`default_nettype wire

// ===== tb/hkra_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the HID keyboard report to ASCII converter: US keymap lookup,
// key history and the queue of characters still due from the block.
// Depends on hkra_pkg for the request/character structs and key codes.

package hkra_tb_pkg;

    import hkra_pkg::*;

    function automatic logic [7:0] slot_code(report_t r, int idx);
        case (idx)
            0:       return r.key_slot_0;
            1:       return r.key_slot_1;
            2:       return r.key_slot_2;
            3:       return r.key_slot_3;
            4:       return r.key_slot_4;
            default: return r.key_slot_5;
        endcase
    endfunction

    // US layout; zero means the code has no character
    function automatic logic [6:0] us_keymap(logic [7:0] code, bit shifted);
        string alnum;
        string punct;
        byte   b;
        alnum = shifted ? "ABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()"
                        : "abcdefghijklmnopqrstuvwxyz1234567890";
        // code 50 (non-US hash) sits in the gap and maps to nothing
        punct = shifted ? "_+{}| :\"~<>?" : "-=[]\\ ;'`,./";
        b = 8'h00;
        if (code >= 8'd4 && code <= 8'd39)
            b = alnum[int'(code) - 4];
        else if (code == 8'd40)
            b = 8'h0d;
        else if (code == 8'd41)
            b = 8'h1b;
        else if (code == 8'd42)
            b = 8'h08;
        else if (code == 8'd43)
            b = 8'h09;
        else if (code == 8'd44)
            b = 8'h20;
        else if (code >= 8'd45 && code <= 8'd56 && code != 8'd50)
            b = punct[int'(code) - 45];
        return b[6:0];
    endfunction

    class char_scoreboard;

        logic [7:0] held_keys [KEY_SLOTS];
        char_t      due_chars [$];
        int         errors;

        function new();
            foreach (held_keys[i])
                held_keys[i] = '0;
            errors = 0;
        endfunction

        task flag_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        // Work out the characters an accepted request should give
        function void note_report(report_t r);
            logic [7:0] now_keys [KEY_SLOTS];
            char_t      run [$];
            logic [6:0] ch;
            logic [7:0] code;
            bit         shifted;
            bit         ctrl_held;
            bit         held;
            bit         letter;
            if (r.req_type == REQ_CLEAR)
            begin
                foreach (held_keys[i])
                    held_keys[i] = '0;
                return;
            end
            shifted   = |(r.modifier_bits & MOD_SHIFT);
            ctrl_held = |(r.modifier_bits & MOD_CTRL);
            foreach (now_keys[i])
                now_keys[i] = slot_code(r, i);
            foreach (now_keys[i])
            begin
                code = now_keys[i];
                held = 1'b0;
                foreach (held_keys[j])
                    if (held_keys[j] == code)
                        held = 1'b1;
                if (code == 8'h00 || held)
                    continue;
                if (code inside {CODE_RIGHT, CODE_LEFT, CODE_DOWN, CODE_UP})
                begin
                    run.push_back(char_t'{CHAR_ESC, 1'b0});
                    run.push_back(char_t'{CHAR_LBRACK, 1'b0});
                    case (code)
                        CODE_RIGHT: ch = 7'h43;
                        CODE_LEFT:  ch = 7'h44;
                        CODE_DOWN:  ch = 7'h42;
                        default:    ch = 7'h41;
                    endcase
                    run.push_back(char_t'{ch, 1'b0});
                end
                else if (code == CODE_DELETE)
                begin
                    run.push_back(char_t'{CHAR_DEL, 1'b0});
                end
                else
                begin
                    ch     = us_keymap(code, shifted);
                    letter = (ch >= 7'h61 && ch <= 7'h7a) || (ch >= 7'h41 && ch <= 7'h5a);
                    if (ctrl_held && letter)
                        ch = (code == CODE_M) ? CHAR_CTRL_M : (ch & CTRL_MASK);
                    if (ch != '0)
                        run.push_back(char_t'{ch, 1'b0});
                end
            end
            held_keys = now_keys;
            if (run.size() > 0)
                run[run.size() - 1].last_of_run = 1'b1;
            foreach (run[k])
                due_chars.push_back(run[k]);
        endfunction

        task check_char(char_t got);
            char_t want;
            if (due_chars.size() == 0)
            begin
                flag_mismatch($sformatf("char 0x%02h last=%0b with nothing due",
                                        got.char_code, got.last_of_run));
                return;
            end
            want = due_chars.pop_front();
            if (got.char_code !== want.char_code)
                flag_mismatch($sformatf("char_code 0x%02h, wanted 0x%02h",
                                        got.char_code, want.char_code));
            if (got.last_of_run !== want.last_of_run)
                flag_mismatch($sformatf("last_of_run %0b, wanted %0b on char 0x%02h",
                                        got.last_of_run, want.last_of_run, want.char_code));
        endtask

    endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top-level testbench for hid_keyboard_report_to_ascii: directed and random
// keyboard requests with idling on both channels, checked by char_scoreboard.
// Depends on hkra_pkg and hkra_tb_pkg.

module tb;

    import hkra_pkg::*;
    import hkra_tb_pkg::*;

    // Worst request gives 18 characters, each of which may sit behind a long
    // receiver stall; this leaves ample margin.
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_GAP      = 40;
    localparam int REPORT_W     = $bits(report_t);

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    report_valid = 1'b0;
    logic    report_stall;
    report_t report       = '0;
    logic    char_valid;
    logic    char_stall   = 1'b0;
    char_t   char_data;

    // Idle rates in percent per cycle, changed per phase
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycles      = 0;

    report_t        last_keys = '0;
    char_scoreboard sb        = new();

    hid_keyboard_report_to_ascii dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data)
    );

    always #10 clk = ~clk;

    // Run limit: a hung block ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Character side: take the character if one was handed over at this edge,
    // then pick the stall for the next cycle. Sampling happens before the
    // block's registers update, so the values seen are those at the edge.
    always @(posedge clk)
    begin
        if (rst_n && char_valid === 1'b1 && char_stall === 1'b0)
            sb.check_char(char_data);
        char_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    function automatic report_t key_report(logic req, logic [7:0] mods,
                                           logic [7:0] k0, logic [7:0] k1,
                                           logic [7:0] k2, logic [7:0] k3,
                                           logic [7:0] k4, logic [7:0] k5);
        return report_t'{req, mods, k0, k1, k2, k3, k4, k5};
    endfunction

    // Typing model: a slot mostly keeps its key, is released, or gets a key
    // from the mapped range, arrows and Delete included; now and then any byte.
    function automatic logic [7:0] evolve_slot(logic [7:0] held);
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return held;
        if (pick < 62)
            return 8'h00;
        if (pick < 92)
            return 8'($urandom_range(4, 82));
        return 8'($urandom_range(0, 255));
    endfunction

    // Present one request and hold it until the block takes it. Valid stays
    // high between back-to-back requests, so it is only lowered for a gap.
    task send_report(report_t r);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            report_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        report_valid <= 1'b1;
        report       <= r;
        do
            @(posedge clk);
        while (report_stall !== 1'b0);
        sb.note_report(r);
    endtask

    task type_phase(int count, int tx_pct, int rx_pct);
        report_t r;
        int      pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                // clear with junk in the ignored fields
                r          = report_t'(REPORT_W'({$urandom, $urandom}));
                r.req_type = REQ_CLEAR;
            end
            else if (pick < 13)
            begin
                // noise: any modifier, any codes
                r          = report_t'(REPORT_W'({$urandom, $urandom}));
                r.req_type = REQ_REPORT;
            end
            else
            begin
                r            = last_keys;
                r.req_type   = REQ_REPORT;
                r.key_slot_0 = evolve_slot(last_keys.key_slot_0);
                r.key_slot_1 = evolve_slot(last_keys.key_slot_1);
                r.key_slot_2 = evolve_slot(last_keys.key_slot_2);
                r.key_slot_3 = evolve_slot(last_keys.key_slot_3);
                r.key_slot_4 = evolve_slot(last_keys.key_slot_4);
                r.key_slot_5 = evolve_slot(last_keys.key_slot_5);
                case ($urandom_range(7))
                    0:       r.modifier_bits = 8'h00;
                    1:       r.modifier_bits = 8'h02;
                    2:       r.modifier_bits = 8'h20;
                    3:       r.modifier_bits = 8'h01;
                    4:       r.modifier_bits = 8'h10;
                    5:       r.modifier_bits = 8'h12;
                    default: r.modifier_bits = 8'($urandom_range(0, 255));
                endcase
                last_keys = r;
            end
            send_report(r);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 17;
        rx_idle_pct = 78;

        // Directed: clear first, then fresh keys, held keys, every column
        send_report(key_report(REQ_CLEAR, 8'h00, 0, 0, 0, 0, 0, 0));
        send_report(key_report(REQ_REPORT, 8'h00, 4, 5, 6, 7, 8, 9));
        // same keys still held: nothing new
        send_report(key_report(REQ_REPORT, 8'h00, 4, 5, 6, 7, 8, 9));
        send_report(key_report(REQ_REPORT, 8'h00, 4, 0, 0, 0, 0, 10));
        send_report(key_report(REQ_REPORT, 8'h00, 0, 0, 0, 0, 0, 0));
        // shifted digits and punctuation, left and right shift
        send_report(key_report(REQ_REPORT, 8'h02, 30, 31, 32, 33, 34, 35));
        send_report(key_report(REQ_REPORT, 8'h20, 45, 46, 47, 48, 49, 51));
        send_report(key_report(REQ_REPORT, 8'h22, 52, 53, 54, 55, 56, 39));
        send_report(key_report(REQ_REPORT, 8'h00, 36, 37, 38, 40, 41, 42));
        send_report(key_report(REQ_REPORT, 8'h00, 43, 44, 45, 46, 47, 48));
        // ctrl folds letters; M gives 28; non-letters pass unchanged
        send_report(key_report(REQ_REPORT, 8'h01, 4, 29, CODE_M, 30, 44, 40));
        send_report(key_report(REQ_REPORT, 8'h30, CODE_M, 29, 5, 49, 0, 0));
        send_report(key_report(REQ_REPORT, 8'h10, CODE_DELETE, 0, 0, 0, 0, 0));
        send_report(key_report(REQ_REPORT, 8'h00, 0, 0, 0, 0, 0, 0));
        // all arrows, two of them repeated in the same request: 18 characters
        send_report(key_report(REQ_REPORT, 8'h00, CODE_RIGHT, CODE_LEFT, CODE_DOWN,
                               CODE_UP, CODE_RIGHT, CODE_LEFT));
        send_report(key_report(REQ_REPORT, 8'h00, 0, 0, 0, 0, 0, 0));
        // unmapped codes, low and high, and codes with the top bit set
        send_report(key_report(REQ_REPORT, 8'hff, 0, 1, 2, 3, 50, 57));
        send_report(key_report(REQ_REPORT, 8'h00, 90, 8'hff, 8'h80, 8'h7f, 8'hcf, 8'hcc));
        send_report(key_report(REQ_REPORT, 8'h00, 8'hd2, 8'h84, 89, 58, 0, 0));
        // a code twice in one request is emitted twice
        send_report(key_report(REQ_REPORT, 8'h00, 4, 4, 5, 5, 0, 6));
        // alt/gui bits alone change nothing
        send_report(key_report(REQ_REPORT, 8'hcc, 4, 5, 7, 0, 0, 0));
        // clear with junk fields, then the same keys count as new again
        send_report(key_report(REQ_CLEAR, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                               8'hff));
        send_report(key_report(REQ_REPORT, 8'h02, 4, 5, 7, 0, 0, 0));
        send_report(key_report(REQ_REPORT, 8'h11, CODE_DELETE, CODE_UP, CODE_M, 8'h0f,
                               30, 0));
        send_report(key_report(REQ_REPORT, 8'h00, 0, 0, 0, 0, 0, 0));

        // Random typing: slow sender/busy receiver, then swapped, then flat out
        type_phase(85, 17, 78);
        type_phase(85, 78, 17);
        type_phase(85, 0, 0);

        report_valid <= 1'b0;
        while (sb.due_chars.size() != 0)
            @(posedge clk);
        // catch any stray characters after the last one due
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/hkra_pkg.sv
hw/rtl/hid_keyboard_report_to_ascii.sv
tb/hkra_scoreboard_pkg.sv
tb/tb.sv
